// File: rtl/bps_pkg.sv
// Shared constants and constant functions for the Blinn-Phong shader.
// Used by bps_unitize, bps_pow, the top level and the testbench; depends on nothing.
`default_nettype none

package bps_pkg;

    // port and field widths
    localparam int IN_VEC_W  = 63;
    localparam int COLOR_W   = 51;
    localparam int CH_W      = 17;
    localparam int OUT_W     = 18;
    localparam int SHIN_W    = 16;
    localparam int UNIT_W    = 16;
    localparam int POW_W     = 51;
    localparam int CFG_IDX_W = 2;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHININESS = 2'd2;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 51'd18447869933568;

    // latency of the normalize unit for a W-bit input component
    function automatic int unit_lat(input int w);
        return w + 28;
    endfunction

    // latency of the power unit for a table of t fraction bits
    function automatic int pow_lat(input int t);
        return 2 * t + 4;
    endfunction

    // floor square root, used only to build constants
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] v;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        v = x;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q1.30, by repeated square roots of 2
    function automatic logic [31:0] exp_const(input int k);
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int j = 1; j < k; j++) begin
            c = isqrt64(c << 30);
        end
        return c[31:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/bps_delay.sv
// Fixed-length shift line that keeps item payload aligned with the units.
// Depends on nothing.
`default_nettype none

module bps_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_sh [0:DEPTH-1];

    // shift one tap per cycle
    always_ff @(posedge i_clk) begin
        r_sh[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_sh[i] <= r_sh[i-1];
        end
    end

    assign o_q = r_sh[DEPTH-1];

endmodule

`default_nettype wire

// File: rtl/bps_unitize.sv
// Pipelined vector normalize: squares, one-bit-per-stage square root,
// one-bit-per-stage rounded divide. Uses bps_pkg.
`default_nettype none

module bps_unitize #(
    parameter int W = 22
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [W-1:0]               i_vec  [0:2],
    output logic                                   o_valid,
    output logic signed [bps_pkg::UNIT_W-1:0]      o_unit [0:2],
    output logic                                   o_nonzero
);

    localparam int SSW = 2 * W + 2;
    localparam int XB  = SSW + 16;
    localparam int NP  = W + 9;
    localparam int RW  = NP + 2;
    localparam int NW  = W + 23;
    localparam int QW  = 15;
    localparam int DRW = NP + 1;
    localparam int UW  = bps_pkg::UNIT_W;

    // stage A: magnitudes and squares
    logic             r_a_vld;
    logic [W-1:0]     r_a_abs [0:2];
    logic             r_a_neg [0:2];
    logic [2*W-1:0]   r_a_sq  [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_a_neg[k] <= i_vec[k][W-1];
            r_a_abs[k] <= i_vec[k][W-1] ? W'(-i_vec[k]) : W'(i_vec[k]);
            r_a_sq[k]  <= (i_vec[k][W-1] ? W'(-i_vec[k]) : W'(i_vec[k])) *
                          (i_vec[k][W-1] ? W'(-i_vec[k]) : W'(i_vec[k]));
        end
    end

    // square root chain, index 0 holds the sum of squares
    logic            r_s_vld  [0:NP];
    logic            r_s_nz   [0:NP];
    logic [XB-1:0]   r_s_x    [0:NP];
    logic [RW-1:0]   r_s_rem  [0:NP];
    logic [NP-1:0]   r_s_root [0:NP];
    logic [W-1:0]    r_s_abs  [0:NP][0:2];
    logic            r_s_neg  [0:NP][0:2];

    logic [SSW-1:0]  n_ss;
    assign n_ss = SSW'(r_a_sq[0]) + SSW'(r_a_sq[1]) + SSW'(r_a_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld[0] <= 1'b0;
        end else begin
            r_s_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_nz[0]   <= (n_ss != '0);
        r_s_x[0]    <= {n_ss, 16'b0};
        r_s_rem[0]  <= '0;
        r_s_root[0] <= '0;
        for (int k = 0; k < 3; k++) begin
            r_s_abs[0][k] <= r_a_abs[k];
            r_s_neg[0][k] <= r_a_neg[k];
        end
    end

    for (genvar i = 0; i < NP; i++) begin : g_sqrt
        logic [RW+1:0] n_remt;
        logic [RW+1:0] n_trial;
        logic          n_ge;

        assign n_remt  = {r_s_rem[i], r_s_x[i][XB-1:XB-2]};
        assign n_trial = (RW+2)'({r_s_root[i], 2'b01});
        assign n_ge    = (n_remt >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[i+1] <= 1'b0;
            end else begin
                r_s_vld[i+1] <= r_s_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_s_nz[i+1]   <= r_s_nz[i];
            r_s_x[i+1]    <= r_s_x[i] << 2;
            r_s_rem[i+1]  <= n_ge ? RW'(n_remt - n_trial) : RW'(n_remt);
            r_s_root[i+1] <= {r_s_root[i][NP-2:0], n_ge};
            for (int k = 0; k < 3; k++) begin
                r_s_abs[i+1][k] <= r_s_abs[i][k];
                r_s_neg[i+1][k] <= r_s_neg[i][k];
            end
        end
    end

    // divide chain: q = (a * 2^22 + len/2) / len
    logic            r_d_vld [0:QW];
    logic            r_d_nz  [0:QW];
    logic [NP-1:0]   r_d_len [0:QW];
    logic            r_d_neg [0:QW][0:2];
    logic [DRW-1:0]  r_d_rem [0:QW][0:2];
    logic [QW-1:0]   r_d_low [0:QW][0:2];
    logic [QW-1:0]   r_d_q   [0:QW][0:2];

    logic [NW-1:0]   n_num [0:2];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num[k] = NW'({r_s_abs[NP][k], 22'b0}) + NW'(r_s_root[NP] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else begin
            r_d_vld[0] <= r_s_vld[NP];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_nz[0]  <= r_s_nz[NP];
        r_d_len[0] <= r_s_root[NP];
        for (int k = 0; k < 3; k++) begin
            r_d_neg[0][k] <= r_s_neg[NP][k];
            r_d_rem[0][k] <= DRW'(n_num[k] >> QW);
            r_d_low[0][k] <= n_num[k][QW-1:0];
            r_d_q[0][k]   <= '0;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [DRW:0] n_remt [0:2];
        logic         n_ge   [0:2];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                n_remt[k] = {r_d_rem[j][k], r_d_low[j][k][QW-1]};
                n_ge[k]   = (n_remt[k] >= (DRW+1)'(r_d_len[j]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[j+1] <= 1'b0;
            end else begin
                r_d_vld[j+1] <= r_d_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d_nz[j+1]  <= r_d_nz[j];
            r_d_len[j+1] <= r_d_len[j];
            for (int k = 0; k < 3; k++) begin
                r_d_neg[j+1][k] <= r_d_neg[j][k];
                r_d_rem[j+1][k] <= n_ge[k] ? DRW'(n_remt[k] - (DRW+1)'(r_d_len[j]))
                                           : DRW'(n_remt[k]);
                r_d_low[j+1][k] <= r_d_low[j][k] << 1;
                r_d_q[j+1][k]   <= {r_d_q[j][k][QW-2:0], n_ge[k]};
            end
        end
    end

    // output: apply sign, zero vector stays zero
    logic           r_o_vld;
    logic           r_o_nz;
    logic signed [UW-1:0] r_o_unit [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_d_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_nz <= r_d_nz[QW];
        for (int k = 0; k < 3; k++) begin
            if (!r_d_nz[QW]) begin
                r_o_unit[k] <= '0;
            end else if (r_d_neg[QW][k]) begin
                r_o_unit[k] <= -$signed(UW'(r_d_q[QW][k]));
            end else begin
                r_o_unit[k] <= $signed(UW'(r_d_q[QW][k]));
            end
        end
    end

    assign o_valid   = r_o_vld;
    assign o_nonzero = r_o_nz;
    assign o_unit    = r_o_unit;

endmodule

`default_nettype wire

// File: rtl/bps_pow.sv
// Pipelined x^shininess through log2 (squaring chain) and exp2 (constant
// product chain). Uses bps_pkg for the exp2 constants and widths.
`default_nettype none

module bps_pow #(
    parameter int T  = 10,
    parameter int XW = 39
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          i_en,
    input  wire logic [XW-1:0]                 i_x,
    input  wire logic [bps_pkg::SHIN_W-1:0]    i_shininess,
    output logic                               o_valid,
    output logic [bps_pkg::POW_W-1:0]          o_pow
);

    localparam int PW  = $clog2(XW);
    localparam int LGW = T + 7;
    localparam int PRW = T + 24;
    localparam int OW  = bps_pkg::POW_W;

    // stage 1: leading one
    logic           r1_vld;
    logic           r1_en;
    logic [XW-1:0]  r1_x;
    logic [PW-1:0]  r1_p;
    logic [PW-1:0]  n1_p;

    always_comb begin
        n1_p = '0;
        for (int i = 0; i < XW; i++) begin
            if (i_x[i]) begin
                n1_p = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_en <= i_en;
        r1_x  <= i_x;
        r1_p  <= n1_p;
    end

    // stage 2: normalize, keep T mantissa bits below the leading one
    logic [XW-1:0]  n2_xn;
    assign n2_xn = r1_x << (PW'(XW - 1) - r1_p);

    logic           r_lv [0:T];
    logic           r_le [0:T];
    logic [30:0]    r_lm [0:T];
    logic [T-1:0]   r_lf [0:T];
    logic [6:0]     r_lp [0:T];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv[0] <= 1'b0;
        end else begin
            r_lv[0] <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_le[0] <= r1_en;
        r_lm[0] <= {1'b1, n2_xn[XW-2 -: T], {(30-T){1'b0}}};
        r_lf[0] <= '0;
        r_lp[0] <= 7'(r1_p) - 7'd24;
    end

    // log2 fraction, one squaring per stage
    for (genvar j = 0; j < T; j++) begin : g_log
        logic [61:0] n_sq;
        logic [31:0] n_mm;
        assign n_sq = 62'(r_lm[j]) * 62'(r_lm[j]);
        assign n_mm = n_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lv[j+1] <= 1'b0;
            end else begin
                r_lv[j+1] <= r_lv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_le[j+1] <= r_le[j];
            r_lp[j+1] <= r_lp[j];
            r_lm[j+1] <= n_mm[31] ? n_mm[31:1] : n_mm[30:0];
            r_lf[j+1] <= {r_lf[j][T-2:0], n_mm[31]};
        end
    end

    // scale by shininess, split into integer and fraction
    logic signed [LGW-1:0] n_lg;
    logic signed [PRW-1:0] n_pl;
    assign n_lg = $signed({r_lp[T], r_lf[T]});
    assign n_pl = n_lg * $signed({1'b0, i_shininess});

    logic                r_ev [0:T];
    logic                r_ee [0:T];
    logic [31:0]         r_er [0:T];
    logic [T-1:0]        r_ef [0:T];
    logic signed [15:0]  r_ei [0:T];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev[0] <= 1'b0;
        end else begin
            r_ev[0] <= r_lv[T];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ee[0] <= r_le[T];
        r_er[0] <= 32'h4000_0000;
        r_ef[0] <= n_pl[T+7:8];
        r_ei[0] <= $signed(n_pl[PRW-1:T+8]);
    end

    // exp2 of the fraction, one constant per stage
    for (genvar j = 0; j < T; j++) begin : g_exp
        localparam logic [31:0] C_K = bps_pkg::exp_const(j + 1);
        logic [63:0] n_prod;
        assign n_prod = 64'(r_er[j]) * 64'(C_K) + 64'h2000_0000;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ev[j+1] <= 1'b0;
            end else begin
                r_ev[j+1] <= r_ev[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_ee[j+1] <= r_ee[j];
            r_ef[j+1] <= r_ef[j];
            r_ei[j+1] <= r_ei[j];
            r_er[j+1] <= r_ef[j][T-1-j] ? n_prod[61:30] : r_er[j];
        end
    end

    // final scale to 16 fraction bits with cap
    logic signed [16:0] n_s;
    logic signed [16:0] n_ns;
    logic [OW-1:0]      n_pow;
    assign n_s  = 17'(r_ei[T]) - 17'sd14;
    assign n_ns = -n_s;

    always_comb begin
        if (!r_ee[T]) begin
            n_pow = '0;
        end else if (n_s > 17'sd19) begin
            n_pow = OW'(1) << 50;
        end else if (n_s >= 17'sd0) begin
            n_pow = OW'(r_er[T]) << n_s[4:0];
        end else if (n_s <= -17'sd40) begin
            n_pow = '0;
        end else begin
            n_pow = OW'(r_er[T] >> n_ns[5:0]);
        end
    end

    logic           r_o_vld;
    logic [OW-1:0]  r_o_pow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_ev[T];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_pow <= n_pow;
    end

    assign o_valid = r_o_vld;
    assign o_pow   = r_o_pow;

endmodule

`default_nettype wire

// File: rtl/blinn_phong_light_shade.sv
// Top level of the Blinn-Phong shader: config registers, vector setup, dot
// products and color math. Uses bps_pkg, bps_delay, bps_unitize, bps_pow.
//
//   channel   handshake                  payload
//   --------  -------------------------  --------------------------------------
//   item in   start && !busy             ray_dir, hit_point, surface_normal,
//                                        light_pos, light_is_point, light_color
//   result    o_done strobe, 1 cycle     out_red, out_green, out_blue
//   config    i_cfg_valid && o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per clock. The pipeline depth is set by the normalize units (L and V
// side by side, then the half vector; square root and divide, one bit per stage)
// and the log2/exp2 power chain (one multiply per stage).
// Synchronous active-low reset clears the valid bits and shininess and loads COLOR_RESET into diffuse and specular.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
`default_nettype none

module blinn_phong_light_shade #(
    parameter int VEC_BITS       = 21,
    parameter int POW_TABLE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [bps_pkg::IN_VEC_W-1:0]      i_ray_dir,
    input  wire logic [bps_pkg::IN_VEC_W-1:0]      i_hit_point,
    input  wire logic [bps_pkg::IN_VEC_W-1:0]      i_surface_normal,
    input  wire logic [bps_pkg::IN_VEC_W-1:0]      i_light_pos,
    input  wire logic                              i_light_is_point,
    input  wire logic [bps_pkg::COLOR_W-1:0]       i_light_color,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bps_pkg::COLOR_W-1:0]       i_cfg_data,
    output logic                                   o_done,
    output logic [bps_pkg::OUT_W-1:0]              o_out_red,
    output logic [bps_pkg::OUT_W-1:0]              o_out_green,
    output logic [bps_pkg::OUT_W-1:0]              o_out_blue
);

    localparam int VB   = VEC_BITS;
    localparam int T    = POW_TABLE_BITS;
    localparam int LW   = VB + 1;
    localparam int HW   = 17;
    localparam int UW   = bps_pkg::UNIT_W;
    localparam int CW   = bps_pkg::CH_W;
    localparam int OW   = bps_pkg::OUT_W;
    localparam int PWW  = bps_pkg::POW_W;
    localparam int COLW = bps_pkg::COLOR_W;
    localparam int NDW  = VB + 19;
    localparam int XW   = NDW - 1;
    localparam int ALAT = bps_pkg::unit_lat(LW);
    localparam int HLAT = bps_pkg::unit_lat(HW);
    localparam int PLAT = bps_pkg::pow_lat(T);
    localparam int NHW  = NDW - 21;
    localparam int DSW  = 2 * CW + NHW + 21;
    localparam int SSW  = 2 * CW + 20;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic [COLW-1:0]             r_diffuse;
    logic [COLW-1:0]             r_specular;
    logic [bps_pkg::SHIN_W-1:0]  r_shininess;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diffuse   <= bps_pkg::COLOR_RESET;
            r_specular  <= bps_pkg::COLOR_RESET;
            r_shininess <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bps_pkg::CFG_DIFFUSE:   r_diffuse   <= i_cfg_data;
                bps_pkg::CFG_SPECULAR:  r_specular  <= i_cfg_data;
                bps_pkg::CFG_SHININESS: r_shininess <= i_cfg_data[bps_pkg::SHIN_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack input vectors
    logic signed [VB-1:0] w_dir [0:2];
    logic signed [VB-1:0] w_hp  [0:2];
    logic signed [VB-1:0] w_nrm [0:2];
    logic signed [VB-1:0] w_lp  [0:2];

    for (genvar k = 0; k < 3; k++) begin : g_unpack
        assign w_dir[k] = i_ray_dir[k*VB +: VB];
        assign w_hp[k]  = i_hit_point[k*VB +: VB];
        assign w_nrm[k] = i_surface_normal[k*VB +: VB];
        assign w_lp[k]  = i_light_pos[k*VB +: VB];
    end

    // stage 0: light vector and register the item
    logic                 r0_vld;
    logic signed [LW-1:0] r0_lv  [0:2];
    logic signed [LW-1:0] r0_dir [0:2];
    logic [3*VB-1:0]      r0_nrm;
    logic [COLW-1:0]      r0_lc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r0_lv[k]  <= i_light_is_point ? LW'(w_lp[k]) - LW'(w_hp[k]) : LW'(w_lp[k]);
            r0_dir[k] <= LW'(w_dir[k]);
        end
        r0_nrm <= i_surface_normal[3*VB-1:0];
        r0_lc  <= i_light_color;
    end

    // normalize L and the ray direction side by side
    logic                  w_avld;
    logic                  w_vvld;
    logic                  w_vok;
    logic signed [UW-1:0]  w_l  [0:2];
    logic signed [UW-1:0]  w_vu [0:2];

    bps_unitize #(.W(LW)) u_unit_l (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r0_vld),
        .i_vec     (r0_lv),
        .o_valid   (w_avld),
        .o_unit    (w_l),
        .o_nonzero ()
    );

    bps_unitize #(.W(LW)) u_unit_v (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r0_vld),
        .i_vec     (r0_dir),
        .o_valid   (w_vvld),
        .o_unit    (w_vu),
        .o_nonzero (w_vok)
    );

    logic [3*VB+COLW-1:0] w_da;
    bps_delay #(.WIDTH(3*VB+COLW), .DEPTH(ALAT)) u_dly_a (
        .i_clk (i_clk),
        .i_d   ({r0_nrm, r0_lc}),
        .o_q   (w_da)
    );

    logic signed [VB-1:0] w_da_nrm [0:2];
    for (genvar k = 0; k < 3; k++) begin : g_da
        assign w_da_nrm[k] = w_da[COLW + k*VB +: VB];
    end

    // stage P1: N.L and N.V products, half vector sum
    logic                   r1_vld;
    logic                   r1_vok;
    logic signed [VB+15:0]  r1_pl  [0:2];
    logic signed [VB+15:0]  r1_pv  [0:2];
    logic signed [HW-1:0]   r1_hs  [0:2];
    logic signed [VB-1:0]   r1_nrm [0:2];
    logic [COLW-1:0]        r1_lc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_avld && w_vvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_vok <= w_vok;
        r1_lc  <= w_da[COLW-1:0];
        for (int k = 0; k < 3; k++) begin
            r1_pl[k]  <= w_da_nrm[k] * w_l[k];
            r1_pv[k]  <= w_da_nrm[k] * w_vu[k];
            r1_hs[k]  <= HW'(w_l[k]) - HW'(w_vu[k]);
            r1_nrm[k] <= w_da_nrm[k];
        end
    end

    // stage P2: face the normal toward the viewer, N.L
    logic signed [VB+17:0] n2_sl;
    logic signed [VB+17:0] n2_sv;
    logic                  n2_flip;
    assign n2_sl   = (VB+18)'(r1_pl[0]) + (VB+18)'(r1_pl[1]) + (VB+18)'(r1_pl[2]);
    assign n2_sv   = (VB+18)'(r1_pv[0]) + (VB+18)'(r1_pv[1]) + (VB+18)'(r1_pv[2]);
    assign n2_flip = (n2_sv > 0);

    logic                  r2_vld;
    logic                  r2_vok;
    logic signed [NDW-1:0] r2_ndl;
    logic [3*LW-1:0]       r2_nrm;
    logic signed [HW-1:0]  r2_hs [0:2];
    logic [COLW-1:0]       r2_lc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_vok <= r1_vok;
        r2_lc  <= r1_lc;
        r2_ndl <= n2_flip ? -NDW'(n2_sl) : NDW'(n2_sl);
        for (int k = 0; k < 3; k++) begin
            r2_hs[k]            <= r1_hs[k];
            r2_nrm[k*LW +: LW]  <= n2_flip ? -LW'(r1_nrm[k]) : LW'(r1_nrm[k]);
        end
    end

    // normalize the half vector
    logic                 w_hvld;
    logic                 w_hok;
    logic signed [UW-1:0] w_h [0:2];

    bps_unitize #(.W(HW)) u_unit_h (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r2_vld),
        .i_vec     (r2_hs),
        .o_valid   (w_hvld),
        .o_unit    (w_h),
        .o_nonzero (w_hok)
    );

    logic [NDW+3*LW+COLW:0] w_dh;
    bps_delay #(.WIDTH(NDW+3*LW+COLW+1), .DEPTH(HLAT)) u_dly_h (
        .i_clk (i_clk),
        .i_d   ({r2_vok, r2_ndl, r2_nrm, r2_lc}),
        .o_q   (w_dh)
    );

    logic signed [LW-1:0] w_dh_nrm [0:2];
    for (genvar k = 0; k < 3; k++) begin : g_dh
        assign w_dh_nrm[k] = w_dh[COLW + k*LW +: LW];
    end

    // stage Q1: N.H products
    logic                  r3_vld;
    logic                  r3_ok;
    logic signed [NDW-1:0] r3_ndl;
    logic signed [VB+16:0] r3_ph [0:2];
    logic [COLW-1:0]       r3_lc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= w_hvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_ok  <= w_dh[NDW+3*LW+COLW] && w_hok;
        r3_ndl <= w_dh[COLW+3*LW +: NDW];
        r3_lc  <= w_dh[COLW-1:0];
        for (int k = 0; k < 3; k++) begin
            r3_ph[k] <= w_dh_nrm[k] * w_h[k];
        end
    end

    // stage Q2: N.H sum, specular enable
    logic signed [NDW-1:0] n4_ndh;
    assign n4_ndh = NDW'(r3_ph[0]) + NDW'(r3_ph[1]) + NDW'(r3_ph[2]);

    logic                  r4_vld;
    logic                  r4_en;
    logic [XW-1:0]         r4_x;
    logic signed [NDW-1:0] r4_ndl;
    logic [COLW-1:0]       r4_lc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_en  <= r3_ok && (n4_ndh > 0);
        r4_x   <= n4_ndh[XW-1:0];
        r4_ndl <= r3_ndl;
        r4_lc  <= r3_lc;
    end

    // specular power
    logic            w_pvld;
    logic [PWW-1:0]  w_pow;

    bps_pow #(.T(T), .XW(XW)) u_pow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r4_vld),
        .i_en        (r4_en),
        .i_x         (r4_x),
        .i_shininess (r_shininess),
        .o_valid     (w_pvld),
        .o_pow       (w_pow)
    );

    logic [NDW+COLW-1:0] w_dp;
    bps_delay #(.WIDTH(NDW+COLW), .DEPTH(PLAT)) u_dly_p (
        .i_clk (i_clk),
        .i_d   ({r4_ndl, r4_lc}),
        .o_q   (w_dp)
    );

    // stage C1: surface color times light color
    logic                  r5_vld;
    logic signed [NDW-1:0] r5_ndl;
    logic [PWW-1:0]        r5_pw;
    logic [2*CW-1:0]       r5_ad [0:2];
    logic [2*CW-1:0]       r5_as [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= w_pvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_ndl <= w_dp[COLW +: NDW];
        r5_pw  <= w_pow;
        for (int k = 0; k < 3; k++) begin
            r5_ad[k] <= (2*CW)'(r_diffuse[k*CW +: CW]) * (2*CW)'(w_dp[k*CW +: CW]);
            r5_as[k] <= (2*CW)'(r_specular[k*CW +: CW]) * (2*CW)'(w_dp[k*CW +: CW]);
        end
    end

    // stage C2: partial products of the diffuse and specular terms
    logic                    r6_vld;
    logic                    r6_pos;
    logic [2*CW+NHW-1:0]     r6_dh [0:2];
    logic [2*CW+19:0]        r6_dl [0:2];
    logic [2*CW+18:0]        r6_sh [0:2];
    logic [2*CW+31:0]        r6_sl [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_pos <= (r5_ndl > 0);
        for (int k = 0; k < 3; k++) begin
            r6_dh[k] <= (2*CW+NHW)'(r5_ad[k]) * (2*CW+NHW)'(r5_ndl[NDW-2:20]);
            r6_dl[k] <= (2*CW+20)'(r5_ad[k]) * (2*CW+20)'(r5_ndl[19:0]);
            r6_sh[k] <= (2*CW+19)'(r5_as[k]) * (2*CW+19)'(r5_pw[PWW-1:32]);
            r6_sl[k] <= (2*CW+32)'(r5_as[k]) * (2*CW+32)'(r5_pw[31:0]);
        end
    end

    // stage C3: shift, saturate, sum
    logic [DSW-1:0] n7_dsum [0:2];
    logic [DSW-1:0] n7_d    [0:2];
    logic [SSW-1:0] n7_s    [0:2];
    logic [OW-1:0]  n7_dsat [0:2];
    logic [OW-1:0]  n7_ssat [0:2];
    logic [OW:0]    n7_tot  [0:2];
    logic [OW-1:0]  n7_out  [0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n7_dsum[k] = (DSW'(r6_dh[k]) << 20) + DSW'(r6_dl[k]);
            n7_d[k]    = n7_dsum[k] >> 40;
            n7_s[k]    = SSW'(r6_sh[k]) + SSW'(r6_sl[k] >> 32);
            n7_dsat[k] = (n7_d[k] > DSW'(bps_pkg::OUT_MAX)) ? bps_pkg::OUT_MAX
                                                           : OW'(n7_d[k]);
            n7_ssat[k] = (n7_s[k] > SSW'(bps_pkg::OUT_MAX)) ? bps_pkg::OUT_MAX
                                                           : OW'(n7_s[k]);
            n7_tot[k]  = (OW+1)'(n7_dsat[k]) + (OW+1)'(n7_ssat[k]);
            if (!r6_pos) begin
                n7_out[k] = '0;
            end else if (n7_tot[k][OW]) begin
                n7_out[k] = bps_pkg::OUT_MAX;
            end else begin
                n7_out[k] = n7_tot[k][OW-1:0];
            end
        end
    end

    logic           r7_vld;
    logic [OW-1:0]  r7_red;
    logic [OW-1:0]  r7_green;
    logic [OW-1:0]  r7_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_red   <= n7_out[0];
        r7_green <= n7_out[1];
        r7_blue  <= n7_out[2];
    end

    assign o_done      = r7_vld;
    assign o_out_red   = r7_red;
    assign o_out_green = r7_green;
    assign o_out_blue  = r7_blue;

endmodule

`default_nettype wire

// File: tb/sv/blinn_phong_light_shade_test.sv
// Testbench for blinn_phong_light_shade: drives shading items and register writes,
// predicts each shaded color in fixed point and checks every result strobe.
// Depends on bps_pkg and the blinn_phong_light_shade RTL.
`timescale 1ns / 1ps

module blinn_phong_light_shade_test;

    localparam int IN_VEC_W  = bps_pkg::IN_VEC_W;
    localparam int COLOR_W   = bps_pkg::COLOR_W;
    localparam int CH_W      = bps_pkg::CH_W;
    localparam int OUT_W     = bps_pkg::OUT_W;
    localparam int SHIN_W    = bps_pkg::SHIN_W;
    localparam int CFG_IDX_W = bps_pkg::CFG_IDX_W;

    localparam logic [OUT_W-1:0]     OUT_MAX       = bps_pkg::OUT_MAX;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE   = bps_pkg::CFG_DIFFUSE;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR  = bps_pkg::CFG_SPECULAR;
    localparam logic [CFG_IDX_W-1:0] CFG_SHININESS = bps_pkg::CFG_SHININESS;
    localparam logic [COLOR_W-1:0]   COLOR_RESET   = bps_pkg::COLOR_RESET;

    localparam int VB       = 21;
    localparam int PTB      = 10;
    localparam int LATENCY  = VB + 2 * PTB + 86;
    localparam int N_RANDOM = 1150;

    typedef longint t_vec3 [3];

    typedef struct {
        logic [IN_VEC_W-1:0] ray_dir;
        logic [IN_VEC_W-1:0] hit_point;
        logic [IN_VEC_W-1:0] normal;
        logic [IN_VEC_W-1:0] light_pos;
        logic                is_point;
        logic [COLOR_W-1:0]  light_color;
    } t_shade_item;

    typedef struct {
        logic [OUT_W-1:0] r;
        logic [OUT_W-1:0] g;
        logic [OUT_W-1:0] b;
    } t_color;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [IN_VEC_W-1:0] i_ray_dir, i_hit_point, i_surface_normal, i_light_pos;
    logic i_light_is_point;
    logic [COLOR_W-1:0] i_light_color;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COLOR_W-1:0] i_cfg_data;
    logic o_done;
    logic [OUT_W-1:0] o_out_red, o_out_green, o_out_blue;

    // predictor copy of the surface registers
    logic [COLOR_W-1:0] diffuse_q;
    logic [COLOR_W-1:0] specular_q;
    logic [SHIN_W-1:0]  shininess_q;

    t_color expected_colors[$];
    int     mismatches;

    blinn_phong_light_shade u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_ray_dir        (i_ray_dir),
        .i_hit_point      (i_hit_point),
        .i_surface_normal (i_surface_normal),
        .i_light_pos      (i_light_pos),
        .i_light_is_point (i_light_is_point),
        .i_light_color    (i_light_color),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root, bitv, rem;
        root = 0;
        rem  = x;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint comp_of(input logic [IN_VEC_W-1:0] v, input int k);
        logic signed [VB-1:0] c;
        c = v[k*VB +: VB];
        return longint'(c);
    endfunction

    // normalize to 14 fraction bits; returns 0 for the zero vector
    function automatic bit to_unit(input t_vec3 v, output t_vec3 u);
        longint unsigned mag [3];
        longint unsigned ss, len, q;
        ss = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = v[k] < 0 ? longint'(-v[k]) : longint'(v[k]);
            ss += mag[k] * mag[k];
        end
        if (ss == 0) begin
            u = '{0, 0, 0};
            return 1'b0;
        end
        len = floor_sqrt(ss << 16);
        for (int k = 0; k < 3; k++) begin
            q    = ((mag[k] << 22) + len / 2) / len;
            u[k] = v[k] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic longint dot(input t_vec3 a, input t_vec3 b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic longint unsigned scale_sat(input longint unsigned a,
                                                  input longint unsigned b,
                                                  input int sh);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        if (p[127:64] != 0) return longint'(OUT_MAX);
        p = p >> sh;
        return p > 128'(OUT_MAX) ? longint'(OUT_MAX) : longint'(p[63:0]);
    endfunction

    // log2 with PTB fraction bits of a value holding 24 fraction bits
    function automatic longint log2_q(input longint unsigned x);
        int lead;
        longint unsigned m, frac;
        lead = 0;
        for (int i = 0; i < 64; i++) if (x[i]) lead = i;
        m = lead >= 30 ? x >> (lead - 30) : x << (30 - lead);
        m = (m >> (30 - PTB)) << (30 - PTB);
        frac = 0;
        for (int k = 0; k < PTB; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(lead) - 24) * (longint'(1) << PTB) + longint'(frac);
    endfunction

    function automatic longint unsigned exp2_q30(input longint unsigned f);
        longint unsigned c, r;
        c = floor_sqrt(64'd1 << 61);
        r = 64'd1 << 30;
        for (int k = 1; k <= PTB; k++) begin
            if (f[PTB-k]) r = (r * c + (64'd1 << 29)) >> 30;
            c = floor_sqrt(c << 30);
        end
        return r;
    endfunction

    // (N.H)^shininess with 16 fraction bits, capped
    function automatic longint unsigned spec_power(input longint unsigned x);
        longint prod, ip, sh;
        longint unsigned r;
        prod = log2_q(x) * longint'(shininess_q);
        ip   = prod >>> (PTB + 8);
        r    = exp2_q30(longint'(prod - (ip <<< (PTB + 8))) >> 8);
        sh   = ip - 14;
        if (sh > 19) return 64'd1 << 50;
        if (sh >= 0) return r << sh;
        if (sh <= -40) return 0;
        return r >> (-sh);
    endfunction

    function automatic t_color shade(input t_shade_item it);
        t_vec3 dir, nrm, lv, lu, vu, hs, hu;
        longint ndl, ndh;
        longint unsigned pw, lc, dc, sc, sum;
        logic [OUT_W-1:0] ch [3];
        bit view_ok;
        t_color res;
        pw = 0;
        for (int k = 0; k < 3; k++) begin
            dir[k] = comp_of(it.ray_dir, k);
            nrm[k] = comp_of(it.normal, k);
            lv[k]  = it.is_point ? comp_of(it.light_pos, k) - comp_of(it.hit_point, k)
                                 : comp_of(it.light_pos, k);
        end
        void'(to_unit(lv, lu));
        view_ok = to_unit(dir, vu);
        for (int k = 0; k < 3; k++) vu[k] = -vu[k];
        // face the normal toward the viewer
        if (dot(nrm, vu) < 0) for (int k = 0; k < 3; k++) nrm[k] = -nrm[k];
        res = '{0, 0, 0};
        ndl = dot(nrm, lu);
        if (ndl <= 0) return res;
        for (int k = 0; k < 3; k++) hs[k] = lu[k] + vu[k];
        if (view_ok && to_unit(hs, hu)) begin
            ndh = dot(nrm, hu);
            if (ndh > 0) pw = spec_power(longint'(ndh));
        end
        for (int k = 0; k < 3; k++) begin
            lc  = it.light_color[k*CH_W +: CH_W];
            dc  = diffuse_q[k*CH_W +: CH_W];
            sc  = specular_q[k*CH_W +: CH_W];
            sum = scale_sat(dc * lc, longint'(ndl), 40) + scale_sat(sc * lc, pw, 32);
            ch[k] = sum > longint'(OUT_MAX) ? OUT_MAX : sum[OUT_W-1:0];
        end
        res.r = ch[0];
        res.g = ch[1];
        res.b = ch[2];
        return res;
    endfunction

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        t_color exp_c;
        if (i_rst_n && o_done) begin
            if (expected_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h %h", o_out_red, o_out_green,
                             o_out_blue);
            end else begin
                exp_c = expected_colors.pop_front();
                if (exp_c.r !== o_out_red || exp_c.g !== o_out_green ||
                    exp_c.b !== o_out_blue) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color mismatch: expected %h %h %h, got %h %h %h",
                                 exp_c.r, exp_c.g, exp_c.b,
                                 o_out_red, o_out_green, o_out_blue);
                end
            end
        end
    end

    // ---------------- drivers ----------------

    // present one item from the current falling edge until accepted
    task automatic send_item(input t_shade_item it);
        i_ray_dir        = it.ray_dir;
        i_hit_point      = it.hit_point;
        i_surface_normal = it.normal;
        i_light_pos      = it.light_pos;
        i_light_is_point = it.is_point;
        i_light_color    = it.light_color;
        start            = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
            @(negedge i_clk);
        end
        expected_colors.push_back(shade(it));
        @(negedge i_clk);
    endtask

    task automatic go_idle(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        wait (expected_colors.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            CFG_DIFFUSE:   diffuse_q   = data;
            CFG_SPECULAR:  specular_q  = data;
            CFG_SHININESS: shininess_q = data[SHIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_surface(input logic [COLOR_W-1:0] d, input logic [COLOR_W-1:0] s,
                               input logic [COLOR_W-1:0] shin);
        drain();
        write_reg(CFG_DIFFUSE, d);
        write_reg(CFG_SPECULAR, s);
        write_reg(CFG_SHININESS, shin);
    endtask

    function automatic logic [IN_VEC_W-1:0] pack3(input longint x, input longint y,
                                                  input longint z);
        logic [VB-1:0] a, b, c;
        a = x[VB-1:0];
        b = y[VB-1:0];
        c = z[VB-1:0];
        return {c, b, a};
    endfunction

    function automatic logic [COLOR_W-1:0] rand_color();
        return COLOR_W'({$urandom(), $urandom()});
    endfunction

    // component: mostly moderate, sometimes full range
    function automatic longint rand_comp();
        case ($urandom_range(0, 5))
            0:       return longint'($signed(21'($urandom())));
            1:       return $urandom_range(0, 1) ? 1048575 : -1048576;
            default: return longint'($urandom_range(0, 8192)) - 4096;
        endcase
    endfunction

    function automatic logic [IN_VEC_W-1:0] rand_vec();
        return pack3(rand_comp(), rand_comp(), rand_comp());
    endfunction

    function automatic t_shade_item make_item(input logic [IN_VEC_W-1:0] dir,
                                              input logic [IN_VEC_W-1:0] hit,
                                              input logic [IN_VEC_W-1:0] nrm,
                                              input logic [IN_VEC_W-1:0] lp,
                                              input logic pt,
                                              input logic [COLOR_W-1:0] lc);
        t_shade_item it;
        it.ray_dir     = dir;
        it.hit_point   = hit;
        it.normal      = nrm;
        it.light_pos   = lp;
        it.is_point    = pt;
        it.light_color = lc;
        return it;
    endfunction

    // ---------------- tests ----------------

    // hand-picked geometry: zero vectors, flips, back lighting, extremes
    task automatic test_special_cases();
        logic [IN_VEC_W-1:0] down, up, zero, mx, mn;
        logic [COLOR_W-1:0] white, full;
        down  = pack3(0, 0, -1024);
        up    = pack3(0, 0, 1024);
        zero  = '0;
        mx    = pack3(1048575, 1048575, 1048575);
        mn    = pack3(-1048576, -1048576, -1048576);
        white = {17'd65536, 17'd65536, 17'd65536};
        full  = '1;
        send_item(make_item(down, zero, up, up, 1'b0, white));
        send_item(make_item(down, zero, up, zero, 1'b0, white));       // zero light vector
        send_item(make_item(down, up, up, up, 1'b1, white));           // light on the hit point
        send_item(make_item(zero, zero, up, up, 1'b0, white));         // zero ray direction
        send_item(make_item(down, zero, up, down, 1'b0, white));       // light from behind
        send_item(make_item(down, zero, down, up, 1'b0, white));       // normal flipped
        send_item(make_item(up, zero, up, up, 1'b0, white));           // L + V zero
        send_item(make_item(down, zero, up, pack3(1024, 0, 1), 1'b0, white)); // grazing
        send_item(make_item(mn, mx, mx, mn, 1'b1, full));
        send_item(make_item(mx, mn, mn, mx, 1'b1, full));
        send_item(make_item(mn, zero, mx, mx, 1'b0, full));
        send_item(make_item(pack3(3, -5, -1000), mn, pack3(1, 2, 900),
                            pack3(100, 200, 300), 1'b1, full));
        send_item(make_item(pack3(-1048576, 0, 0), zero, pack3(1048575, 0, 0),
                            pack3(1048575, 1, 0), 1'b0, '0));
        go_idle(1);
    endtask

    // random geometry in bursts with random gaps
    task automatic test_random_scenes(input int count);
        int sent, burst;
        t_shade_item it;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++) begin
                it = make_item(rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                               1'($urandom()), rand_color());
                // mostly keep the viewer in front and the light lit
                if ($urandom_range(0, 3) != 0) begin
                    it.ray_dir[3*VB-1]   = 1'b1;
                    it.normal[3*VB-1]    = 1'b0;
                    it.light_pos[3*VB-1] = 1'b0;
                    it.is_point          = 1'b0;
                end
                send_item(it);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 9));
        end
        go_idle(1);
    endtask

    initial begin
        start            = 1'b0;
        i_ray_dir        = '0;
        i_hit_point      = '0;
        i_surface_normal = '0;
        i_light_pos      = '0;
        i_light_is_point = 1'b0;
        i_light_color    = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_DIFFUSE;
        i_cfg_data       = '0;
        diffuse_q        = COLOR_RESET;
        specular_q       = COLOR_RESET;
        shininess_q      = '0;
        mismatches       = 0;
        i_rst_n          = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_special_cases();
        test_random_scenes(N_RANDOM / 6);

        set_surface('1, '1, 51'hFFFF);
        test_special_cases();
        test_random_scenes(N_RANDOM / 6);

        set_surface('0, '0, '0);
        test_random_scenes(N_RANDOM / 12);

        set_surface(rand_color(), rand_color(), 51'h0100);
        test_special_cases();
        test_random_scenes(N_RANDOM / 4);

        for (int ph = 0; ph < 3; ph++) begin
            set_surface(rand_color(), rand_color(), COLOR_W'({$urandom(), $urandom()}));
            test_random_scenes(N_RANDOM / 9);
        end

        drain();
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("blinn_phong_light_shade_test: done, clean");
        else
            $display("blinn_phong_light_shade_test: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("blinn_phong_light_shade_test: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/bps_pkg.sv
rtl/bps_delay.sv
rtl/bps_unitize.sv
rtl/bps_pow.sv
rtl/blinn_phong_light_shade.sv
tb/sv/blinn_phong_light_shade_test.sv
